FILE: rtl/core/chunk_reassembly_tracker_macros.svh
// ----------------------------------------------------------------------------
// Chunk reassembly tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CHUNK_REASSEMBLY_TRACKER_MACROS_SVH
`define CHUNK_REASSEMBLY_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/crt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk reassembly tracker package
// Sizes, status codes, controller states and a shared helper function.
// ----------------------------------------------------------------------------
package crt_pkg;

  // Table geometry.
  localparam int MAX_CHUNKS  = 64;
  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOTAL_W = $clog2(MAX_CHUNKS + 1);
  localparam int BIT_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);

  // Fixed field widths.
  localparam int ID_W        = 32;
  localparam int IDX_W       = 16;
  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int RETRY_W     = 4;
  localparam int MASK_W      = 64;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [DELAY_W-1:0] STALE_DELAY_RESET = DELAY_W'(1500);
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = RETRY_W'(5);

  typedef enum logic [STATUS_W-1:0] {
    ST_ZERO_TOTAL = 4'd0,
    ST_BAD_INDEX  = 4'd1,
    ST_TOO_MANY   = 4'd2,
    ST_TABLE_FULL = 4'd3,
    ST_STORED     = 4'd4,
    ST_DUPLICATE  = 4'd5,
    ST_COMPLETE   = 4'd6,
    ST_RETRANSMIT = 4'd7,
    ST_GIVE_UP    = 4'd8
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STALE_DELAY = 1'd0,
    CFG_RETRY_LIMIT = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_UPDATE,
    S_SWEEP,
    S_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              search_clear;
    logic              search_step;
    logic              use_sel;
    logic              reject_emit;
    logic              chunk_commit;
    logic              sweep_hit;
    logic              sweep_flush;
    logic [SLOT_W-1:0] ptr;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic sweep_elig;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

  // One result item.
  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [MASK_W-1:0]   mask;
    logic [COUNT_W-1:0]  count;
    logic [RETRY_W-1:0]  retry;
    logic                mismatch;
    logic                last;
  } result_t;

  // Mask with the low 'total' bits set.
  function automatic logic [MAX_CHUNKS-1:0] full_mask(input logic [TOTAL_W-1:0] total);
    logic [MAX_CHUNKS-1:0] m;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      m[i] = (TOTAL_W'(i) < total);
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/crt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk reassembly tracker datapath
// Slot table, input capture, search registers, result holding and output.
// ----------------------------------------------------------------------------
module crt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  crt_pkg::dp_cmd_t             cmd,
  output crt_pkg::dp_stat_t            stat,
  input  logic                         cfg_write,
  input  logic [crt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [crt_pkg::ID_W-1:0]     transfer_id,
  input  logic [crt_pkg::IDX_W-1:0]    chunk_index,
  input  logic [crt_pkg::IDX_W-1:0]    chunk_total,
  input  logic [crt_pkg::TIME_W-1:0]   time_now,
  input  logic                         out_stall,
  output logic                         out_valid,
  output crt_pkg::result_t             out_res
);
  import crt_pkg::*;

  // Configuration registers.
  logic [DELAY_W-1:0] stale_delay;
  logic [RETRY_W-1:0] retry_limit;

  // Captured item.
  logic [ID_W-1:0]   c_id;
  logic [IDX_W-1:0]  c_idx;
  logic [IDX_W-1:0]  c_total;
  logic [TIME_W-1:0] c_now;

  // Slot table.
  logic                  slot_valid   [SLOTS];
  logic [ID_W-1:0]       slot_id      [SLOTS];
  logic [TOTAL_W-1:0]    slot_total   [SLOTS];
  logic [MAX_CHUNKS-1:0] slot_recv    [SLOTS];
  logic [TOTAL_W-1:0]    slot_cnt     [SLOTS];
  logic [TIME_W-1:0]     slot_time    [SLOTS];
  logic [RETRY_W-1:0]    slot_retries [SLOTS];

  // Search results.
  logic              found_v;
  logic [SLOT_W-1:0] found_slot;
  logic              free_v;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] sel_slot;

  // Pending sweep result.
  logic    pend_valid;
  result_t pend;

  // Read port.
  logic [SLOT_W-1:0]     rd_addr;
  logic                  r_valid;
  logic [ID_W-1:0]       r_id;
  logic [TOTAL_W-1:0]    r_total;
  logic [MAX_CHUNKS-1:0] r_recv;
  logic [TOTAL_W-1:0]    r_cnt;
  logic [TIME_W-1:0]     r_time;
  logic [RETRY_W-1:0]    r_retries;

  // Chunk evaluation.
  logic                  reject;
  status_t               reject_code;
  logic                  is_new;
  logic                  table_full;
  logic                  mismatch;
  logic                  late_bad;
  logic [TOTAL_W-1:0]    eff_total;
  logic [MAX_CHUNKS-1:0] eff_recv;
  logic [TOTAL_W-1:0]    eff_cnt;
  logic [BIT_W-1:0]      bit_pos;
  logic [MAX_CHUNKS-1:0] new_recv;
  logic [TOTAL_W-1:0]    new_cnt;
  logic                  dup;
  logic                  done;
  logic                  chunk_write;
  logic [TOTAL_W-1:0]    mask_total;
  logic [MAX_CHUNKS-1:0] fm;
  result_t               chunk_res;

  // Sweep evaluation.
  logic [TIME_W-1:0]  age;
  logic               sweep_elig;
  logic               can_retry;
  logic [RETRY_W-1:0] next_retries;
  result_t            sweep_res;

  // Output register control.
  logic    out_free;
  logic    out_load;
  result_t out_next;

  assign sel_slot = found_v ? found_slot : free_slot;
  assign rd_addr  = cmd.use_sel ? sel_slot : cmd.ptr;

  assign r_valid   = slot_valid[rd_addr];
  assign r_id      = slot_id[rd_addr];
  assign r_total   = slot_total[rd_addr];
  assign r_recv    = slot_recv[rd_addr];
  assign r_cnt     = slot_cnt[rd_addr];
  assign r_time    = slot_time[rd_addr];
  assign r_retries = slot_retries[rd_addr];

  // Early rejection on the announced total and index alone.
  always_comb begin
    reject      = 1'b1;
    reject_code = ST_ZERO_TOTAL;
    if (c_total == '0) begin
      reject_code = ST_ZERO_TOTAL;
    end else if (c_idx >= c_total) begin
      reject_code = ST_BAD_INDEX;
    end else if (c_total > IDX_W'(MAX_CHUNKS)) begin
      reject_code = ST_TOO_MANY;
    end else begin
      reject = 1'b0;
    end
  end

  // Effective slot contents for the chunk, a fresh slot when the id is new.
  assign is_new     = !found_v;
  assign table_full = !found_v && !free_v;
  assign eff_total  = is_new ? c_total[TOTAL_W-1:0] : r_total;
  assign eff_recv   = is_new ? '0 : r_recv;
  assign eff_cnt    = is_new ? '0 : r_cnt;
  assign mismatch   = !is_new && (IDX_W'(r_total) != c_total);
  assign late_bad   = mismatch && (c_idx >= IDX_W'(r_total));
  assign bit_pos    = c_idx[BIT_W-1:0];
  assign dup        = eff_recv[bit_pos];
  assign new_recv   = eff_recv | (MAX_CHUNKS'(1) << bit_pos);
  assign new_cnt    = eff_cnt + TOTAL_W'(1);
  assign done       = (new_cnt == eff_total);
  assign chunk_write = cmd.chunk_commit && !table_full && !late_bad;

  // One mask generator serves both chunk and sweep results.
  assign mask_total = cmd.use_sel ? eff_total : r_total;
  assign fm         = full_mask(mask_total);

  // Chunk result.
  always_comb begin
    chunk_res          = '0;
    chunk_res.id       = c_id;
    chunk_res.last     = 1'b1;
    chunk_res.mismatch = mismatch;
    if (table_full) begin
      chunk_res.status   = ST_TABLE_FULL;
      chunk_res.mismatch = 1'b0;
    end else if (late_bad) begin
      chunk_res.status = ST_BAD_INDEX;
    end else if (dup) begin
      chunk_res.status = ST_DUPLICATE;
      chunk_res.mask   = MASK_W'(fm & ~eff_recv);
      chunk_res.count  = COUNT_W'(eff_total - eff_cnt);
    end else if (done) begin
      chunk_res.status = ST_COMPLETE;
    end else begin
      chunk_res.status = ST_STORED;
      chunk_res.mask   = MASK_W'(fm & ~new_recv);
      chunk_res.count  = COUNT_W'(eff_total - new_cnt);
    end
  end

  // Sweep evaluation of the slot under the pointer.
  assign age          = c_now - r_time;
  assign sweep_elig   = r_valid && (age > TIME_W'(stale_delay)) && (r_cnt != r_total);
  assign can_retry    = (r_retries < retry_limit);
  assign next_retries = r_retries + RETRY_W'(1);

  always_comb begin
    sweep_res          = '0;
    sweep_res.status   = can_retry ? ST_RETRANSMIT : ST_GIVE_UP;
    sweep_res.id       = r_id;
    sweep_res.mask     = MASK_W'(fm & ~r_recv);
    sweep_res.count    = COUNT_W'(r_total - r_cnt);
    sweep_res.retry    = can_retry ? next_retries : r_retries;
  end

  // Output register source selection.
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    out_load = 1'b0;
    out_next = pend;
    if (cmd.reject_emit) begin
      out_load        = 1'b1;
      out_next        = '0;
      out_next.status = reject_code;
      out_next.id     = c_id;
      out_next.last   = 1'b1;
    end else if (cmd.chunk_commit) begin
      out_load = 1'b1;
      out_next = chunk_res;
    end else if (cmd.sweep_hit && pend_valid) begin
      out_load      = 1'b1;
      out_next.last = 1'b0;
    end else if (cmd.sweep_flush) begin
      out_load      = 1'b1;
      out_next.last = 1'b1;
    end
  end

  assign stat.reject     = reject;
  assign stat.sweep_elig = sweep_elig;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  // Control state: configuration, valid bits, search flags, handshake flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_delay <= STALE_DELAY_RESET;
      retry_limit <= RETRY_LIMIT_RESET;
      found_v     <= 1'b0;
      free_v      <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_valid[s] <= 1'b0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_STALE_DELAY: stale_delay <= cfg_data[DELAY_W-1:0];
          CFG_RETRY_LIMIT: retry_limit <= cfg_data[RETRY_W-1:0];
          default: ;
        endcase
      end

      if (cmd.search_clear) begin
        found_v <= 1'b0;
        free_v  <= 1'b0;
      end else if (cmd.search_step) begin
        if (r_valid && !found_v && (r_id == c_id)) begin
          found_v <= 1'b1;
        end
        if (!r_valid && !free_v) begin
          free_v <= 1'b1;
        end
      end

      if (chunk_write) begin
        slot_valid[sel_slot] <= dup || !done;
      end

      if (cmd.sweep_hit) begin
        pend_valid <= 1'b1;
      end else if (cmd.sweep_flush) begin
        pend_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_id    <= transfer_id;
      c_idx   <= chunk_index;
      c_total <= chunk_total;
      c_now   <= time_now;
    end

    if (cmd.search_step) begin
      if (r_valid && !found_v && (r_id == c_id)) begin
        found_slot <= cmd.ptr;
      end
      if (!r_valid && !free_v) begin
        free_slot <= cmd.ptr;
      end
    end

    if (chunk_write) begin
      slot_id[sel_slot]      <= c_id;
      slot_total[sel_slot]   <= eff_total;
      slot_recv[sel_slot]    <= dup ? eff_recv : new_recv;
      slot_cnt[sel_slot]     <= dup ? eff_cnt : new_cnt;
      slot_time[sel_slot]    <= c_now;
      slot_retries[sel_slot] <= is_new ? '0 : r_retries;
    end

    // A retransmit counts a retry and restarts the stale timer.
    if (cmd.sweep_hit && can_retry) begin
      slot_retries[cmd.ptr] <= next_retries;
      slot_time[cmd.ptr]    <= c_now;
    end

    if (cmd.sweep_hit) begin
      pend <= sweep_res;
    end

    if (out_load) begin
      out_res <= out_next;
    end
  end

endmodule

FILE: rtl/core/crt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk reassembly tracker controller
// Sequences the slot walk for chunk lookups and maintenance sweeps.
// ----------------------------------------------------------------------------
module crt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               op,
  output logic               in_stall,
  input  crt_pkg::dp_stat_t  stat,
  output crt_pkg::dp_cmd_t   cmd
);
  import crt_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [SLOT_W-1:0]  ptr;
  logic [SLOT_W-1:0]  ptr_next;
  logic [RES_W-1:0]   res_cnt;
  logic [RES_W-1:0]   res_cnt_next;

  logic ptr_last;
  logic sweep_wait;
  logic sweep_take;
  logic limit_hit;

  assign ptr_last   = (ptr == SLOT_W'(SLOTS - 1));
  assign sweep_wait = stat.sweep_elig && stat.pend_valid && !stat.out_free;
  assign sweep_take = stat.sweep_elig && !sweep_wait;
  assign limit_hit  = sweep_take && (res_cnt + RES_W'(1) == RES_W'(MAX_RESULTS));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = op ? S_SWEEP : S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.reject) begin
          state_next = S_SEARCH;
        end else if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (ptr_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (!sweep_wait && (ptr_last || limit_hit)) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Slot pointer and sweep result count.
  always_comb begin
    ptr_next     = ptr;
    res_cnt_next = res_cnt;
    if (state == S_IDLE) begin
      ptr_next     = '0;
      res_cnt_next = '0;
    end else if (state == S_SEARCH) begin
      ptr_next = ptr_last ? '0 : ptr + SLOT_W'(1);
    end else if (state == S_SWEEP && !sweep_wait) begin
      ptr_next = ptr_last ? '0 : ptr + SLOT_W'(1);
      if (sweep_take) begin
        res_cnt_next = res_cnt + RES_W'(1);
      end
    end
  end

  // Commands.
  always_comb begin
    cmd              = '0;
    cmd.ptr          = ptr;
    in_stall         = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_CHECK: begin
        cmd.search_clear = 1'b1;
        cmd.reject_emit  = stat.reject && stat.out_free;
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
      end
      S_UPDATE: begin
        cmd.use_sel      = 1'b1;
        cmd.chunk_commit = stat.out_free;
      end
      S_SWEEP: begin
        cmd.sweep_hit = sweep_take;
      end
      S_FLUSH: begin
        cmd.sweep_flush = stat.pend_valid && stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ptr     <= '0;
      res_cnt <= '0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      res_cnt <= res_cnt_next;
    end
  end

endmodule

FILE: rtl/core/chunk_reassembly_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk reassembly tracker
// Tracks chunked transfers in an eight-slot table and issues retransmits.
// ----------------------------------------------------------------------------
// A chunk item is accepted, then screened on its announced total and index,
// then looked up across the slots, one slot per cycle, to find the transfer
// or the lowest free slot, and then the slot is updated and the result is
// loaded once the output is free. A chunk that fails the screening is only
// accepted and screened, and its result is loaded once the output is free.
// A sweep item visits one slot per cycle, holding on a slot while a waiting
// result is held by output stall, and then releases its final result, if
// any. The slot walk is set by the slot table's single read port. Results
// leave through an output register, and a sweep keeps one further result in
// a holding register so that the final one can carry last. Configuration
// writes are taken in any cycle and must only be made while the block is
// idle.
module chunk_reassembly_tracker (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration.
  input  logic                             cfg_write,
  input  logic [crt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crt_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [crt_pkg::ID_W-1:0]         transfer_id,
  input  logic [crt_pkg::IDX_W-1:0]        chunk_index,
  input  logic [crt_pkg::IDX_W-1:0]        chunk_total,
  input  logic [crt_pkg::TIME_W-1:0]       time_now,
  // Output channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [crt_pkg::STATUS_W-1:0]     status,
  output logic [crt_pkg::ID_W-1:0]         result_id,
  output logic [crt_pkg::MASK_W-1:0]       missing_mask,
  output logic [crt_pkg::COUNT_W-1:0]      absent_count,
  output logic [crt_pkg::RETRY_W-1:0]      retry_number,
  output logic                             total_mismatch,
  output logic                             last
);
  import crt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  out_res;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  crt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .transfer_id (transfer_id),
    .chunk_index (chunk_index),
    .chunk_total (chunk_total),
    .time_now    (time_now),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_res     (out_res)
  );

  // Result fields onto the ports.
  assign status         = out_res.status;
  assign result_id      = out_res.id;
  assign missing_mask   = out_res.mask;
  assign absent_count   = out_res.count;
  assign retry_number   = out_res.retry;
  assign total_mismatch = out_res.mismatch;
  assign last           = out_res.last;

endmodule

FILE: rtl/core/crt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk reassembly tracker checker
// Port-level assertions on result items, bound to the top level.
// ----------------------------------------------------------------------------
`include "chunk_reassembly_tracker_macros.svh"

module crt_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [crt_pkg::STATUS_W-1:0]  status,
  input  logic [crt_pkg::MASK_W-1:0]    missing_mask,
  input  logic [crt_pkg::COUNT_W-1:0]   absent_count,
  input  logic [crt_pkg::RETRY_W-1:0]   retry_number,
  input  logic                          total_mismatch,
  input  logic                          last
);
  import crt_pkg::*;

  logic stalled;
  logic no_mask_st;
  logic sweep_st;
  logic chunk_st;
  logic mask_empty;
  logic sweep_ok;
  logic chunk_ok;

  // Status groups and the shape each group of result items must have.
  assign stalled    = out_valid && out_stall;
  assign no_mask_st = (status == ST_COMPLETE) || (status == ST_TABLE_FULL) ||
                      (status == ST_ZERO_TOTAL) || (status == ST_TOO_MANY) ||
                      (status == ST_BAD_INDEX);
  assign sweep_st   = (status == ST_RETRANSMIT) || (status == ST_GIVE_UP);
  assign chunk_st   = (status == ST_STORED) || (status == ST_DUPLICATE) ||
                      (status == ST_COMPLETE);
  assign mask_empty = (missing_mask == '0) && (absent_count == '0);
  assign sweep_ok   = (missing_mask != '0) && (absent_count != '0) && !total_mismatch;
  assign chunk_ok   = last && (retry_number == '0);

  // A stalled result item holds its status.
  `CRT_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(status), "stalled item changed")

  // Rejections and completions carry no mask.
  `CRT_ASSERT_SAME(a_empty_mask, out_valid && no_mask_st, mask_empty, "mask on a rejected chunk")

  // Sweep results always name missing chunks and never flag a total mismatch.
  `CRT_ASSERT_SAME(a_sweep_res, out_valid && sweep_st, sweep_ok, "malformed sweep result")

  // Chunk results are single items with no retry count.
  `CRT_ASSERT_SAME(a_chunk_res, out_valid && chunk_st, chunk_ok, "malformed chunk result")

endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker (.*);
